// ===== design/word_hash_set_insert_lookup_unit_defines.svh =====
// Assertion macros used by the checker file of the word dictionary unit.
`ifndef WORD_HASH_SET_INSERT_LOOKUP_UNIT_DEFINES_SVH
`define WORD_HASH_SET_INSERT_LOOKUP_UNIT_DEFINES_SVH

// Property checked on every rising clock edge while reset is released.
`define WHSI_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define WHSI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/whsi_pkg.sv =====
package whsi_pkg;

    // Dictionary geometry.
    localparam int HASH_MOD = 31;
    localparam int SLOTS    = 4;
    localparam int WORD_LEN = 16;
    localparam int ROWS     = 128;
    localparam int CH_W     = 7;

    // Derived sizes.
    localparam int BUCKETS   = ROWS * HASH_MOD;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int ENTRIES   = BUCKETS * SLOTS;
    localparam int ENT_W     = $clog2(ENTRIES);
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCNT_W    = $clog2(SLOTS + 1);
    localparam int LEN_W     = $clog2(WORD_LEN + 1);
    localparam int IDX_W     = $clog2(WORD_LEN);
    localparam int HASH_W    = (HASH_MOD > 2) ? $clog2(HASH_MOD) : 1;
    localparam int SUM_W     = $clog2(HASH_MOD + 127);
    localparam int MOD_STEPS = (HASH_MOD + 126) / HASH_MOD;
    localparam int WORD_W    = WORD_LEN * CH_W;
    localparam int ROW_W     = SLOTS * LEN_W;

    // Queue between the character front end and the dictionary engine.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Result fields.
    localparam int STATUS_W  = 3;
    localparam int OUT_LEN_W = 5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

    // Operation codes carried on the user sideband.
    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_LOOKUP = 1'b1;

    // Characters dropped once in second place.
    localparam logic [CH_W-1:0] CH_APOS  = 7'd39;
    localparam logic [CH_W-1:0] CH_SLASH = 7'd47;

    // One finished word handed from the front end to the engine.
    typedef struct packed {
        logic              func;
        logic              too_long;
        logic [LEN_W-1:0]  len;
        logic [HASH_W-1:0] hash;
        logic [WORD_W-1:0] word;
    } t_job;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LEN,
        BK_SCAN,
        BK_CMP
    } t_back_state;

    // Lowercase the letters A to Z, leave every other code alone.
    function automatic logic [CH_W-1:0] to_lower(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = c;
        if (c >= 7'("A") && c <= 7'("Z")) begin
            r = c + 7'd32;
        end
        return r;
    endfunction

    // Split letter for a first character; zero where none is defined.
    function automatic logic [CH_W-1:0] split_letter(input logic [CH_W-1:0] c);
        logic [7:0] r;
        case ({1'b0, c})
            "a": r = "n";
            "b": r = "l";
            "c": r = "o";
            "d": r = "i";
            "e": r = "n";
            "f": r = "l";
            "g": r = "l";
            "h": r = "i";
            "i": r = "n";
            "j": r = "o";
            "k": r = "i";
            "l": r = "i";
            "m": r = "h";
            "n": r = "i";
            "o": r = "s";
            "p": r = "l";
            "q": r = "u";
            "r": r = "h";
            "s": r = "o";
            "t": r = "r";
            "u": r = "p";
            "v": r = "i";
            "w": r = "h";
            "x": r = "y";
            "y": r = "f";
            "z": r = "y";
            default: r = 8'd0;
        endcase
        return r[CH_W-1:0];
    endfunction

    // Running hash: (h + c) mod HASH_MOD by a short compare-subtract chain.
    function automatic logic [HASH_W-1:0] hash_add(input logic [HASH_W-1:0] h,
                                                   input logic [CH_W-1:0] c);
        logic [SUM_W-1:0] v;
        v = SUM_W'(h) + SUM_W'(c);
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (v >= SUM_W'(HASH_MOD)) begin
                v = v - SUM_W'(HASH_MOD);
            end
        end
        return v[HASH_W-1:0];
    endfunction

    // Bucket index from the row rule and the hash of a finished word.
    function automatic logic [BKT_W-1:0] bucket_of(input t_job j);
        logic [CH_W-1:0] first;
        logic [CH_W-1:0] second;
        logic [CH_W-1:0] row;
        first  = j.word[CH_W-1:0];
        second = (j.len >= LEN_W'(2)) ? j.word[2*CH_W-1:CH_W] : '0;
        row    = (second < split_letter(first)) ? first : first + 7'd96;
        return BKT_W'(BKT_W'(row) * BKT_W'(HASH_MOD) + BKT_W'(j.hash));
    endfunction

endpackage

// ===== design/whsi_front.sv =====
module whsi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    input  logic [6:0]    i_ch,
    input  logic          i_last,
    input  logic          i_hold,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output whsi_pkg::t_job o_job
);

    logic [whsi_pkg::LEN_W-1:0]  r_count, n_count;
    logic [whsi_pkg::HASH_W-1:0] r_hash, n_hash;
    logic                        r_too_long, n_too_long;
    logic                        r_drop_done, n_drop_done;
    logic [whsi_pkg::WORD_W-1:0] r_word, n_word;
    logic [whsi_pkg::CH_W-1:0]   ch_norm;
    logic                        keep;
    logic                        accept;

    // A character is taken only when a finished word would find room in the queue.
    assign o_ready = !i_hold && !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && i_last;

    // Normalize the character and fold it into the word being built.
    always_comb begin
        n_count     = r_count;
        n_hash      = r_hash;
        n_too_long  = r_too_long;
        n_drop_done = r_drop_done;
        n_word      = r_word;
        ch_norm     = i_ch;
        keep        = 1'b1;
        if (r_count == '0) begin
            ch_norm = whsi_pkg::to_lower(i_ch);
        end else if (r_count == whsi_pkg::LEN_W'(1)) begin
            if (!r_drop_done && (i_ch == whsi_pkg::CH_APOS || i_ch == whsi_pkg::CH_SLASH)) begin
                keep        = 1'b0;
                n_drop_done = 1'b1;
            end else begin
                ch_norm = whsi_pkg::to_lower(i_ch);
            end
        end
        if (keep) begin
            if (r_count < whsi_pkg::LEN_W'(whsi_pkg::WORD_LEN)) begin
                if (r_count != '0) begin
                    n_hash = whsi_pkg::hash_add(r_hash, ch_norm);
                end
                n_word[r_count[whsi_pkg::IDX_W-1:0]*whsi_pkg::CH_W +: whsi_pkg::CH_W] = ch_norm;
                n_count = r_count + 1'b1;
            end else begin
                n_too_long = 1'b1;
            end
        end
    end

    // The finished word as the engine sees it.
    always_comb begin
        o_job.func     = i_func;
        o_job.too_long = n_too_long;
        o_job.len      = n_count;
        o_job.hash     = n_hash;
        o_job.word     = n_word;
    end

    // Per-word state returns to zero once the last character is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hash      <= '0;
            r_too_long  <= 1'b0;
            r_drop_done <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_count     <= '0;
                r_hash      <= '0;
                r_too_long  <= 1'b0;
                r_drop_done <= 1'b0;
            end else begin
                r_count     <= n_count;
                r_hash      <= n_hash;
                r_too_long  <= n_too_long;
                r_drop_done <= n_drop_done;
            end
        end
    end

    // Character buffer; entries past the current length are never compared.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== design/whsi_queue.sv =====
module whsi_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  whsi_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output whsi_pkg::t_job o_head
);

    whsi_pkg::t_job               r_mem [whsi_pkg::Q_DEPTH];
    logic [whsi_pkg::Q_AW-1:0]    r_wr_ptr;
    logic [whsi_pkg::Q_AW-1:0]    r_rd_ptr;
    logic [whsi_pkg::Q_CW-1:0]    r_count;

    assign o_full  = (r_count == whsi_pkg::Q_CW'(whsi_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== design/whsi_back.sv =====
module whsi_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  whsi_pkg::t_job                 i_head,
    input  logic                           i_out_ready,
    output logic                           o_pop,
    output logic                           o_clearing,
    output logic                           o_out_valid,
    output logic [whsi_pkg::STATUS_W-1:0]  o_status,
    output logic [whsi_pkg::OUT_LEN_W-1:0] o_word_length
);

    whsi_pkg::t_back_state           r_state, n_state;
    logic [whsi_pkg::BKT_W-1:0]      r_clr_addr, n_clr_addr;
    whsi_pkg::t_job                  r_job, n_job;
    logic [whsi_pkg::BKT_W-1:0]      r_bucket, n_bucket;
    logic [whsi_pkg::SCNT_W-1:0]     r_slot, n_slot;
    logic                            r_out_valid, n_out_valid;
    logic [whsi_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [whsi_pkg::OUT_LEN_W-1:0]  r_out_len, n_out_len;

    // Slot lengths, one bucket per row, and stored words, one slot per row.
    logic [whsi_pkg::ROW_W-1:0]      len_mem [whsi_pkg::BUCKETS];
    logic [whsi_pkg::WORD_W-1:0]     word_mem [whsi_pkg::ENTRIES];
    logic [whsi_pkg::ROW_W-1:0]      r_len_row;
    logic [whsi_pkg::WORD_W-1:0]     r_word_rd;

    logic                            len_we;
    logic [whsi_pkg::BKT_W-1:0]      len_waddr;
    logic [whsi_pkg::ROW_W-1:0]      len_wdata;
    logic                            word_we;
    logic [whsi_pkg::SLOT_W-1:0]     ent_slot;
    logic [whsi_pkg::ENT_W-1:0]      ent_addr;
    logic [whsi_pkg::SLOT_W-1:0]     free_idx;
    logic                            free_found;
    logic [whsi_pkg::LEN_W-1:0]      cur_len;
    logic                            word_match;

    assign o_clearing    = (r_state == whsi_pkg::BK_CLEAR);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_word_length = r_out_len;

    // First empty slot in the bucket that was read.
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int j = whsi_pkg::SLOTS - 1; j >= 0; j--) begin
            if (r_len_row[j*whsi_pkg::LEN_W +: whsi_pkg::LEN_W] == '0) begin
                free_idx   = whsi_pkg::SLOT_W'(j);
                free_found = 1'b1;
            end
        end
    end

    // Length of the slot under the lookup cursor.
    assign cur_len = r_len_row[r_slot[whsi_pkg::SLOT_W-1:0]*whsi_pkg::LEN_W +: whsi_pkg::LEN_W];

    // Inserts address the free slot, lookups the cursor slot.
    assign ent_slot = (r_job.func == whsi_pkg::FN_INSERT) ? free_idx
                                                          : r_slot[whsi_pkg::SLOT_W-1:0];
    assign ent_addr = whsi_pkg::ENT_W'(whsi_pkg::ENT_W'(r_bucket) * whsi_pkg::ENT_W'(whsi_pkg::SLOTS)
                                       + whsi_pkg::ENT_W'(ent_slot));

    // Compare the stored word with the current one over its length only.
    always_comb begin
        word_match = 1'b1;
        for (int i = 0; i < whsi_pkg::WORD_LEN; i++) begin
            if ((whsi_pkg::LEN_W'(i) < r_job.len) &&
                (r_word_rd[i*whsi_pkg::CH_W +: whsi_pkg::CH_W] !=
                 r_job.word[i*whsi_pkg::CH_W +: whsi_pkg::CH_W])) begin
                word_match = 1'b0;
            end
        end
    end

    // Sequencer for the clearing pass and the per-word probe.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_job       = r_job;
        n_bucket    = r_bucket;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out_len   = r_out_len;
        o_pop       = 1'b0;
        len_we      = 1'b0;
        len_waddr   = r_bucket;
        len_wdata   = r_len_row;
        word_we     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            whsi_pkg::BK_CLEAR: begin
                len_we     = 1'b1;
                len_waddr  = r_clr_addr;
                len_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == whsi_pkg::BKT_W'(whsi_pkg::BUCKETS - 1)) begin
                    n_state = whsi_pkg::BK_IDLE;
                end
            end
            whsi_pkg::BK_IDLE: begin
                if (!i_empty && (!r_out_valid || i_out_ready)) begin
                    o_pop    = 1'b1;
                    n_job    = i_head;
                    n_slot   = '0;
                    n_bucket = whsi_pkg::bucket_of(i_head);
                    if (i_head.too_long) begin
                        n_out_valid = 1'b1;
                        n_status    = whsi_pkg::ST_TOO_LONG;
                        n_out_len   = whsi_pkg::OUT_LEN_W'(whsi_pkg::WORD_LEN);
                    end else begin
                        n_state = whsi_pkg::BK_LEN;
                    end
                end
            end
            whsi_pkg::BK_LEN: begin
                n_state = whsi_pkg::BK_SCAN;
            end
            whsi_pkg::BK_SCAN: begin
                n_out_len = whsi_pkg::OUT_LEN_W'(r_job.len);
                if (r_job.func == whsi_pkg::FN_INSERT) begin
                    n_out_valid = 1'b1;
                    n_state     = whsi_pkg::BK_IDLE;
                    if (free_found) begin
                        len_we = 1'b1;
                        len_wdata[free_idx*whsi_pkg::LEN_W +: whsi_pkg::LEN_W] = r_job.len;
                        word_we  = 1'b1;
                        n_status = whsi_pkg::ST_INSERTED;
                    end else begin
                        n_status = whsi_pkg::ST_FULL;
                    end
                end else if (r_slot == whsi_pkg::SCNT_W'(whsi_pkg::SLOTS) || cur_len == '0) begin
                    n_out_valid = 1'b1;
                    n_status    = whsi_pkg::ST_NOT_FOUND;
                    n_state     = whsi_pkg::BK_IDLE;
                end else if (cur_len == r_job.len) begin
                    n_state = whsi_pkg::BK_CMP;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            whsi_pkg::BK_CMP: begin
                if (word_match) begin
                    n_out_valid = 1'b1;
                    n_status    = whsi_pkg::ST_FOUND;
                    n_out_len   = whsi_pkg::OUT_LEN_W'(r_job.len);
                    n_state     = whsi_pkg::BK_IDLE;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = whsi_pkg::BK_SCAN;
                end
            end
            default: begin
                n_state = whsi_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= whsi_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_bucket  <= n_bucket;
        r_status  <= n_status;
        r_out_len <= n_out_len;
    end

    // Slot-length memory, registered read of the current bucket.
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        r_len_row <= len_mem[r_bucket];
    end

    // Stored-word memory, registered read of the addressed slot.
    always_ff @(posedge i_clk) begin
        if (word_we) begin
            word_mem[ent_addr] <= r_job.word;
        end
        r_word_rd <= word_mem[ent_addr];
    end

endmodule

// ===== design/word_hash_set_insert_lookup_unit.sv =====
// Characters are taken one per cycle unless the unit is clearing or the queue is full; a
// word's result is registered once it has left the queue and, if not too long, the
// engine's probe. The engine takes no new word until its slot probe through the single-port
// stored-word memory is done and its result is taken; a two-word queue lets characters
// stream meanwhile. Reset is synchronous, active low; after it a clearing pass, one bucket
// row a cycle, empties the slot-length memory, and s_axis_tready stays low until it ends.
module word_hash_set_insert_lookup_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [6:0] ch, [7] zero
    input  logic       s_axis_tuser,   // [0] func
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] status, [7:3] word_length
);

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic           clearing;
    whsi_pkg::t_job front_job;
    whsi_pkg::t_job head_job;
    logic [whsi_pkg::STATUS_W-1:0]  status;
    logic [whsi_pkg::OUT_LEN_W-1:0] word_length;

    // Character front end: normalization, hash and buffer.
    whsi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_func   (s_axis_tuser),
        .i_ch     (s_axis_tdata[6:0]),
        .i_last   (s_axis_tlast),
        .i_hold   (clearing),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    // Finished words waiting for the engine.
    whsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // Dictionary engine with the result register.
    whsi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_job),
        .i_out_ready   (m_axis_tready),
        .o_pop         (q_pop),
        .o_clearing    (clearing),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (status),
        .o_word_length (word_length)
    );

    assign m_axis_tdata = {word_length, status};

endmodule

// ===== design/whsi_checker.sv =====
`include "word_hash_set_insert_lookup_unit_defines.svh"

module whsi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // Reset empties the result register and starts the clearing pass.
    `WHSI_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!m_axis_tvalid && !s_axis_tready), "reset left the unit active")

    // Only the five defined status codes appear.
    `WHSI_ASSERT_RUN(a_status_code, m_axis_tvalid |-> (m_axis_tdata[2:0] <= whsi_pkg::ST_TOO_LONG), "undefined status code")

    // A too-long word reports the saturated length.
    `WHSI_ASSERT_RUN(a_too_long_len, (m_axis_tvalid && m_axis_tdata[2:0] == whsi_pkg::ST_TOO_LONG) |-> (m_axis_tdata[7:3] == whsi_pkg::OUT_LEN_W'(whsi_pkg::WORD_LEN)), "too-long length wrong")

    // A stalled result holds.
    `WHSI_ASSERT_RUN(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind word_hash_set_insert_lookup_unit whsi_checker u_whsi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
